// File: hdl/mep_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mep_pkg
// Shared widths, register indexes and the coordinate saturation helper for
// the escape-time pixel block.
// ----------------------------------------------------------------------------
package mep_pkg;

  localparam int COORD_W    = 32;          // Q4.28 coordinate width
  localparam int SIZE_W     = 13;          // image size register width
  localparam int MUL_W      = 33;          // shared multiplier operand width
  localparam int PROD_W     = 2 * MUL_W;   // shared multiplier product width
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_CNT_W  = 9;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_REAL_START   = 3'd0,
    CFG_REAL_END     = 3'd1,
    CFG_IMAG_START   = 3'd2,
    CFG_IMAG_END     = 3'd3,
    CFG_IMAGE_WIDTH  = 3'd4,
    CFG_IMAGE_HEIGHT = 3'd5,
    CFG_BLUE_DOUBLED = 3'd6
  } cfg_addr_t;

  // clamp a wide signed value to the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [PROD_W-1:0] v
  );
    logic [PROD_W-COORD_W:0] top;
    logic signed [COORD_W-1:0] res;
    top = v[PROD_W-1:COORD_W-1];
    if (top == '0 || top == '1) begin
      res = v[COORD_W-1:0];
    end else if (v[PROD_W-1]) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: hdl/mandelbrot_escape_pixel.sv
`default_nettype none
// Steps: each axis mapping is one product plus a divide on the shared divider. Each loop
//   pass steps through S_MUL_XX, S_MUL_YY, S_MUL_XY and S_UPDATE on the one shared
//   33x33 multiplier. The colour bytes take S_GREY_MUL, S_BLUE_MUL and S_COLOUR_END.
// One item at a time: busy is high until the strobe cycle, which can accept the next item.
// Synchronous reset idles the sequencer and sets the config registers to defaults.
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel
// Escape-time iteration for one pixel in signed fixed point: maps the row and
// column to c, iterates z = z*z + c and scales the count to colour bytes.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel #(
  parameter int ITER_LIMIT = 256,
  parameter int FRAC_BITS  = 28,
  parameter int INDEX_BITS = 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [INDEX_BITS-1:0]            row_index,
  input  wire logic [INDEX_BITS-1:0]            col_index,
  input  wire logic                             cfg_we,
  input  wire logic [mep_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [mep_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                                  done,
  output logic [7:0]                            blue,
  output logic [7:0]                            green,
  output logic [7:0]                            red,
  output logic [mep_pkg::OUT_CNT_W-1:0]         iterations
);
  import mep_pkg::*;

  localparam int DVD_W = INDEX_BITS + COORD_W;
  localparam int CNT_W = $clog2(ITER_LIMIT + 1);
  localparam int DSR_W = SIZE_W;
  localparam logic [PROD_W-1:0] BOUND = PROD_W'(4) << FRAC_BITS;
  // count scaling by reciprocal: numerator times rounding error stays below 2^CLR_SHIFT
  localparam int CLR_SHIFT = 9 + 2 * $clog2(ITER_LIMIT);
  localparam logic [63:0] CLR_RECIP_FULL =
    ((64'd1 << CLR_SHIFT) + 64'(ITER_LIMIT) - 64'd1) / 64'(ITER_LIMIT);
  localparam logic [MUL_W-1:0] CLR_RECIP = CLR_RECIP_FULL[MUL_W-1:0];

  typedef enum logic [10:0] {
    S_IDLE       = 11'b00000000001,
    S_MAP_MUL    = 11'b00000000010,
    S_MAP_START  = 11'b00000000100,
    S_MAP_WAIT   = 11'b00000001000,
    S_MUL_XX     = 11'b00000010000,
    S_MUL_YY     = 11'b00000100000,
    S_MUL_XY     = 11'b00001000000,
    S_UPDATE     = 11'b00010000000,
    S_GREY_MUL   = 11'b00100000000,
    S_BLUE_MUL   = 11'b01000000000,
    S_COLOUR_END = 11'b10000000000
  } state_t;

  state_t state, state_next;

  // configuration
  logic signed [COORD_W-1:0] real_start, real_end, imag_start, imag_end;
  logic [SIZE_W-1:0]         row_div, col_div;
  logic                      blue_doubled;

  // item state
  logic [INDEX_BITS-1:0]     row_r, col_r;
  logic signed [MUL_W-1:0]   span_re, span_im;
  logic                      map_imag;
  logic                      map_neg;
  logic signed [COORD_W-1:0] cr, ci, x, y;
  logic [CNT_W-1:0]          n_cnt;
  logic signed [PROD_W-1:0]  xx, diff;
  logic                      escape;

  // shared units
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic                      div_start, div_busy, div_done;
  logic [DVD_W-1:0]          div_dividend, div_quo;
  logic [DSR_W-1:0]          div_divisor;

  logic                      accept;
  logic [PROD_W-1:0]         mul_abs;
  logic [PROD_W-1:0]         mag;
  logic signed [PROD_W-1:0]  map_base, map_quo, map_sum;
  logic signed [PROD_W-1:0]  nx_wide, ny_wide;
  logic [CNT_W+7:0]          num255;
  logic [CNT_W+8:0]          num510;
  logic [PROD_W-1:0]         clr_quo;
  logic [SIZE_W-1:0]         size_sel;
  logic                      at_limit;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  mep_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  mep_div #(
    .DVD_W (DVD_W),
    .DSR_W (DSR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---- operand selection ----
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MAP_MUL: begin
        mul_a = map_imag ? span_im : span_re;
        mul_b = map_imag ? {{(MUL_W-INDEX_BITS){1'b0}}, col_r}
                         : {{(MUL_W-INDEX_BITS){1'b0}}, row_r};
      end
      S_MUL_XX: begin
        mul_a = {x[COORD_W-1], x};
        mul_b = {x[COORD_W-1], x};
      end
      S_MUL_YY: begin
        mul_a = {y[COORD_W-1], y};
        mul_b = {y[COORD_W-1], y};
      end
      S_MUL_XY: begin
        mul_a = {x[COORD_W-1], x};
        mul_b = {y[COORD_W-1], y};
      end
      S_GREY_MUL: begin
        mul_a = MUL_W'(num255);
        mul_b = CLR_RECIP;
      end
      S_BLUE_MUL: begin
        mul_a = MUL_W'(num510);
        mul_b = CLR_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_abs  = mul_p[PROD_W-1] ? PROD_W'(-mul_p) : PROD_W'(mul_p);
  assign num255   = {n_cnt, 8'b0} - {8'b0, n_cnt};
  assign num510   = {num255, 1'b0};
  assign clr_quo  = mul_p >> CLR_SHIFT;
  assign size_sel = map_imag ? col_div : row_div;

  assign div_start    = (state == S_MAP_START);
  assign div_dividend = DVD_W'(mul_abs);
  // a zero size divides as one
  assign div_divisor  = (size_sel == '0) ? DSR_W'(1) : size_sel;

  // ---- datapath arithmetic ----
  assign map_base = PROD_W'(map_imag ? imag_start : real_start);
  assign map_quo  = {{(PROD_W-DVD_W){1'b0}}, div_quo};
  assign map_sum  = map_neg ? (map_base - map_quo) : (map_base + map_quo);
  assign mag      = PROD_W'(xx) + PROD_W'(mul_p);
  assign nx_wide  = (diff >>> FRAC_BITS) + PROD_W'(cr);
  assign ny_wide  = (mul_p >>> (FRAC_BITS - 1)) + PROD_W'(ci);
  assign at_limit = (n_cnt >= CNT_W'(ITER_LIMIT));

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (start) state_next = S_MAP_MUL;
      S_MAP_MUL:    state_next = S_MAP_START;
      S_MAP_START:  state_next = S_MAP_WAIT;
      S_MAP_WAIT: begin
        if (div_done) state_next = map_imag ? S_MUL_XX : S_MAP_MUL;
      end
      S_MUL_XX:     state_next = S_MUL_YY;
      S_MUL_YY:     state_next = S_MUL_XY;
      S_MUL_XY:     state_next = S_UPDATE;
      S_UPDATE:     state_next = (escape || at_limit) ? S_GREY_MUL : S_MUL_XX;
      S_GREY_MUL:   state_next = S_BLUE_MUL;
      S_BLUE_MUL:   state_next = S_COLOUR_END;
      S_COLOUR_END: state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      n_cnt        <= '0;
      real_start   <= -32'sd536870912;
      real_end     <= 32'sd268435456;
      imag_start   <= -32'sd268435456;
      imag_end     <= 32'sd268435456;
      row_div      <= SIZE_W'(1024);
      col_div      <= SIZE_W'(1024);
      blue_doubled <= 1'b1;
    end else begin
      state <= state_next;
      done  <= (state == S_COLOUR_END);
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_REAL_START:   real_start   <= cfg_wdata;
          CFG_REAL_END:     real_end     <= cfg_wdata;
          CFG_IMAG_START:   imag_start   <= cfg_wdata;
          CFG_IMAG_END:     imag_end     <= cfg_wdata;
          CFG_IMAGE_WIDTH:  row_div      <= cfg_wdata[SIZE_W-1:0];
          CFG_IMAGE_HEIGHT: col_div      <= cfg_wdata[SIZE_W-1:0];
          CFG_BLUE_DOUBLED: blue_doubled <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (accept) begin
        n_cnt <= '0;
      end else if (state == S_UPDATE && !escape && !at_limit) begin
        n_cnt <= n_cnt + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          row_r    <= row_index;
          col_r    <= col_index;
          span_re  <= MUL_W'(real_end) - MUL_W'(real_start);
          span_im  <= MUL_W'(imag_end) - MUL_W'(imag_start);
          map_imag <= 1'b0;
          x        <= '0;
          y        <= '0;
        end
      end
      S_MAP_START: map_neg <= mul_p[PROD_W-1];
      S_MAP_WAIT: begin
        if (div_done) begin
          if (map_imag) ci <= sat_coord(map_sum);
          else          cr <= sat_coord(map_sum);
          map_imag <= 1'b1;
        end
      end
      S_MUL_YY: xx <= mul_p;
      S_MUL_XY: begin
        // mul_p holds y*y here
        escape <= (mag >> FRAC_BITS) > BOUND;
        diff   <= xx - mul_p;
      end
      S_UPDATE: begin
        if (!escape && !at_limit) begin
          x <= sat_coord(nx_wide);
          y <= sat_coord(ny_wide);
        end
      end
      S_BLUE_MUL: begin
        // mul_p holds the grey product here
        green      <= clr_quo[7:0];
        red        <= clr_quo[7:0];
        blue       <= clr_quo[7:0];
        iterations <= OUT_CNT_W'(n_cnt);
      end
      S_COLOUR_END: begin
        if (blue_doubled) begin
          blue <= (clr_quo > PROD_W'(255)) ? 8'hFF : clr_quo[7:0];
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");
  a_done_from_colour: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_COLOUR_END))
    else $error("result strobe outside colour stage");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    n_cnt <= CNT_W'(ITER_LIMIT))
    else $error("iteration count beyond limit");
  a_div_kick: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAP_START) |=> div_busy)
    else $error("divider not running after mapping start");
`endif

endmodule
`default_nettype wire

// File: hdl/mep_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mep_mul
// Shared signed multiplier with a registered product. Serves the axis
// mappings, the three products of each iteration and the two colour products.
// ----------------------------------------------------------------------------
module mep_mul (
  input  wire logic                                 clk,
  input  wire logic signed [mep_pkg::MUL_W-1:0]     a,
  input  wire logic signed [mep_pkg::MUL_W-1:0]     b,
  output logic signed [mep_pkg::PROD_W-1:0]         p
);
  import mep_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

// File: hdl/mep_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mep_div
// Unsigned restoring divider, one quotient bit per cycle. Serves both axis
// mappings, where the divisor is a size register.
// ----------------------------------------------------------------------------
module mep_div #(
  parameter int DVD_W = 44,
  parameter int DSR_W = 13
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DSR_W-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);
  import mep_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   trial_diff;

  // remainder stays below the divisor, so DSR_W bits hold it before the shift
  assign trial      = {rem, quotient[DVD_W-1]};
  assign trial_diff = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial_diff[DSR_W]) begin
        rem      <= trial_diff[DSR_W-1:0];
        quotient <= {quotient[DVD_W-2:0], 1'b1};
      end else begin
        rem      <= trial[DSR_W-1:0];
        quotient <= {quotient[DVD_W-2:0], 1'b0};
      end
    end
  end

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a run");
`endif

endmodule
`default_nettype wire
